@@ rtl/nzp_pkg.sv @@
// ----------------------------------------------------------------------------
// nzp_pkg
// Shared types and codes for the nested zone time profiler: request and
// response words, the per-zone statistics record and command/status codes.
// ----------------------------------------------------------------------------
package nzp_pkg;

  localparam int CMD_W     = 2;
  localparam int ZONE_ID_W = 12;
  localparam int BYTES_W   = 32;
  localparam int TICK_W    = 64;
  localparam int STATUS_W  = 2;
  localparam int NEST_W    = 7;

  localparam int ZONES_DEF       = 4096;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_ENTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZONE0     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [ZONE_ID_W-1:0] zone_id;
    logic [BYTES_W-1:0]   bytes_done;
    logic [TICK_W-1:0]    now_ticks;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ZONE_ID_W-1:0] zone_out;
    logic [TICK_W-1:0]    self_ticks;
    logic [TICK_W-1:0]    total_ticks;
    logic [TICK_W-1:0]    hits;
    logic [TICK_W-1:0]    byte_sum;
    logic [NEST_W-1:0]    nest_level;
  } rsp_word_t;

  // One row of the zone statistics memory.
  typedef struct packed {
    logic [TICK_W-1:0] self_ticks;
    logic [TICK_W-1:0] total_ticks;
    logic [TICK_W-1:0] hits;
    logic [TICK_W-1:0] byte_sum;
  } zone_stats_t;

endpackage

@@ rtl/nzp_ram.sv @@
// ----------------------------------------------------------------------------
// nzp_ram
// Generic single-port synchronous RAM with a registered read port. A write
// takes priority; the read data holds its value until the next read.
// ----------------------------------------------------------------------------
module nzp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/nested_zone_time_profiler_unit.sv @@
// ----------------------------------------------------------------------------
// nested_zone_time_profiler_unit
// Per-zone timing statistics with a bounded stack of open zones.
//
// Requests arrive on req (valid/ready) as enter, exit or read words, each
// with a timestamp; every request returns exactly one response word on rsp
// (valid/ready) holding a status and the statistics of one zone.
// Zone statistics live in a ZONES x 256-bit single-port RAM, the open-zone
// stack in a STACK_DEPTH-entry single-port RAM; each has one access a cycle.
// Enter and read: the zone row is read in S_ISSUE and the response word is
// registered in S_FIN, where an accepted enter also writes the row and frame.
// Exit with open zones: the frame read, the zone read and the parent read are
// serialized on those ports; the zone row and the response follow in S_XP and
// the parent write in S_XW (skipped when a zone is its own parent). A new word
// is taken only back in S_IDLE. After reset the statistics RAM is cleared one
// row a cycle, all ZONES rows, with req_ready low. The response register holds
// a finished word while rsp_ready is low; the next request is still accepted
// and waits at its final step until the response slot is free.
// ----------------------------------------------------------------------------
module nested_zone_time_profiler_unit #(
  parameter int ZONES       = nzp_pkg::ZONES_DEF,
  parameter int STACK_DEPTH = nzp_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  nzp_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output nzp_pkg::rsp_word_t rsp
);

  localparam int ZW  = $clog2(ZONES);
  localparam int SW  = $clog2(STACK_DEPTH + 1);
  localparam int FAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TW  = nzp_pkg::TICK_W;
  localparam int IDW = nzp_pkg::ZONE_ID_W;
  localparam int FW  = 2 * TW + 2 * ZW;
  localparam int QW  = 48;

  // Reduction of the zone id modulo ZONES by a reciprocal multiply, exact
  // for every id of IDW bits.
  localparam int RSHIFT = IDW + ZW;
  localparam longint unsigned RMUL =
    ((64'd1 << RSHIFT) + longint'(ZONES) - 64'd1) / longint'(ZONES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_FRM   = 3'd4;
  localparam logic [2:0] S_XZ    = 3'd5;
  localparam logic [2:0] S_XP    = 3'd6;
  localparam logic [2:0] S_XW    = 3'd7;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [ZW-1:0] clr_addr;

  logic [nzp_pkg::CMD_W-1:0]    cmd_r;
  logic [IDW-1:0]               raw_r;
  logic [IDW-1:0]               quo_r;
  logic [nzp_pkg::BYTES_W-1:0]  bytes_r;
  logic [TW-1:0]                now_r;
  logic [QW-1:0]                prod;

  logic [ZW-1:0]                cur_zone;
  logic [ZW-1:0]                cur_parent;
  logic [nzp_pkg::STATUS_W-1:0] status_r;
  logic                         do_push;
  logic [TW-1:0]                elapsed_r;
  logic [TW-1:0]                snap_r;
  nzp_pkg::zone_stats_t         z_hold;

  logic [SW-1:0] stack_top;
  logic [SW-1:0] top_dec;
  logic [SW-1:0] top_inc;
  logic [ZW-1:0] open_parent;
  logic          stack_full;

  logic [31:0]   rem_wide;
  logic [ZW-1:0] red_zone;

  logic [ZW-1:0]                issue_zone;
  logic [nzp_pkg::STATUS_W-1:0] issue_status;
  logic                         issue_push;

  logic                 zone_we;
  logic                 zone_re;
  logic [ZW-1:0]        zone_addr;
  nzp_pkg::zone_stats_t zone_wdata;
  nzp_pkg::zone_stats_t zone_rdata;

  logic           frm_we;
  logic           frm_re;
  logic [FAW-1:0] frm_addr;
  logic [FW-1:0]  frm_wdata;
  logic [FW-1:0]  frm_rdata;
  logic [TW-1:0]  frm_start_f;
  logic [TW-1:0]  frm_snap_f;
  logic [ZW-1:0]  frm_zone_f;
  logic [ZW-1:0]  frm_par_f;

  nzp_pkg::zone_stats_t enter_upd;
  nzp_pkg::zone_stats_t exit_upd;
  nzp_pkg::zone_stats_t par_upd;

  logic               out_free;
  logic               rsp_load;
  logic               push_fire;
  nzp_pkg::rsp_word_t rsp_next;

  nzp_ram #(
    .WIDTH ($bits(nzp_pkg::zone_stats_t)),
    .DEPTH (ZONES)
  ) u_zone_ram (
    .clk   (clk),
    .we    (zone_we),
    .re    (zone_re),
    .addr  (zone_addr),
    .wdata (zone_wdata),
    .rdata (zone_rdata)
  );

  nzp_ram #(
    .WIDTH (FW),
    .DEPTH (STACK_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frm_we),
    .re    (frm_re),
    .addr  (frm_addr),
    .wdata (frm_wdata),
    .rdata (frm_rdata)
  );

  assign req_ready  = (state == S_IDLE);
  assign out_free   = !rsp_valid || rsp_ready;
  assign stack_full = (stack_top == SW'(STACK_DEPTH));
  assign top_dec    = stack_top - SW'(1);
  assign top_inc    = stack_top + SW'(1);
  assign prod       = QW'(req.zone_id) * QW'(RMUL);
  assign rem_wide   = 32'(raw_r) - 32'(quo_r) * 32'(ZONES);
  assign red_zone   = ZW'(rem_wide);
  assign push_fire  = (state == S_FIN) && out_free && do_push;

  // Frame layout: start timestamp, total-time snapshot, zone, parent.
  assign frm_start_f = frm_rdata[FW-1 -: TW];
  assign frm_snap_f  = frm_rdata[FW-TW-1 -: TW];
  assign frm_zone_f  = frm_rdata[2*ZW-1 -: ZW];
  assign frm_par_f   = frm_rdata[ZW-1:0];

  always_comb begin
    enter_upd          = zone_rdata;
    enter_upd.byte_sum = zone_rdata.byte_sum + TW'(bytes_r);

    // When the zone is its own parent the add and subtract cancel.
    exit_upd             = z_hold;
    exit_upd.hits        = z_hold.hits + TW'(1);
    exit_upd.total_ticks = snap_r + elapsed_r;
    exit_upd.self_ticks  = (cur_parent == cur_zone) ? z_hold.self_ticks
                                                     : z_hold.self_ticks + elapsed_r;

    par_upd            = zone_rdata;
    par_upd.self_ticks = zone_rdata.self_ticks - elapsed_r;
  end

  always_comb begin
    issue_zone   = red_zone;
    issue_status = nzp_pkg::ST_OK;
    issue_push   = 1'b0;
    if (cmd_r == nzp_pkg::CMD_EXIT) begin
      issue_zone   = '0;
      issue_status = nzp_pkg::ST_UNDERFLOW;
    end else if (cmd_r == nzp_pkg::CMD_ENTER) begin
      if (red_zone == '0) begin
        issue_status = nzp_pkg::ST_ZONE0;
      end else if (stack_full) begin
        issue_status = nzp_pkg::ST_OVERFLOW;
      end else begin
        issue_push = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    zone_we    = 1'b0;
    zone_re    = 1'b0;
    zone_addr  = cur_zone;
    zone_wdata = z_hold;
    frm_we     = 1'b0;
    frm_re     = 1'b0;
    frm_addr   = stack_top[FAW-1:0];
    frm_wdata  = {now_r, zone_rdata.total_ticks, cur_zone, open_parent};
    rsp_load   = 1'b0;
    rsp_next   = rsp;

    case (state)
      S_CLEAR: begin
        zone_we    = 1'b1;
        zone_addr  = clr_addr;
        zone_wdata = '0;
        if (clr_addr == ZW'(ZONES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (cmd_r == nzp_pkg::CMD_EXIT && stack_top != '0) begin
          frm_re     = 1'b1;
          frm_addr   = top_dec[FAW-1:0];
          state_next = S_FRM;
        end else begin
          zone_re    = 1'b1;
          zone_addr  = issue_zone;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          rsp_load            = 1'b1;
          rsp_next.status     = status_r;
          rsp_next.zone_out   = IDW'(cur_zone);
          rsp_next.self_ticks = zone_rdata.self_ticks;
          rsp_next.total_ticks = zone_rdata.total_ticks;
          rsp_next.hits       = zone_rdata.hits;
          rsp_next.byte_sum   = do_push ? enter_upd.byte_sum : zone_rdata.byte_sum;
          rsp_next.nest_level = nzp_pkg::NEST_W'(do_push ? top_inc : stack_top);
          state_next          = S_IDLE;
          if (do_push) begin
            zone_we    = 1'b1;
            zone_wdata = enter_upd;
            frm_we     = 1'b1;
          end
        end
      end
      S_FRM: begin
        zone_re    = 1'b1;
        zone_addr  = frm_zone_f;
        state_next = S_XZ;
      end
      S_XZ: begin
        zone_re    = 1'b1;
        zone_addr  = cur_parent;
        state_next = S_XP;
      end
      S_XP: begin
        if (out_free) begin
          zone_we              = 1'b1;
          zone_wdata           = exit_upd;
          rsp_load             = 1'b1;
          rsp_next.status      = nzp_pkg::ST_OK;
          rsp_next.zone_out    = IDW'(cur_zone);
          rsp_next.self_ticks  = exit_upd.self_ticks;
          rsp_next.total_ticks = exit_upd.total_ticks;
          rsp_next.hits        = exit_upd.hits;
          rsp_next.byte_sum    = exit_upd.byte_sum;
          rsp_next.nest_level  = nzp_pkg::NEST_W'(stack_top);
          state_next           = (cur_parent == cur_zone) ? S_IDLE : S_XW;
        end
      end
      S_XW: begin
        zone_we    = 1'b1;
        zone_addr  = cur_parent;
        zone_wdata = par_upd;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      stack_top   <= '0;
      open_parent <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ZW'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (push_fire) begin
        stack_top   <= top_inc;
        open_parent <= cur_zone;
      end
      if (state == S_FRM) begin
        stack_top <= top_dec;
      end
      if (state == S_XP && out_free) begin
        open_parent <= cur_parent;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd_r   <= req.cmd;
      raw_r   <= req.zone_id;
      quo_r   <= IDW'(prod >> RSHIFT);
      bytes_r <= req.bytes_done;
      now_r   <= req.now_ticks;
    end
    if (state == S_ISSUE) begin
      cur_zone <= issue_zone;
      status_r <= issue_status;
      do_push  <= issue_push;
    end
    if (state == S_FRM) begin
      cur_zone   <= frm_zone_f;
      cur_parent <= frm_par_f;
      elapsed_r  <= now_r - frm_start_f;
      snap_r     <= frm_snap_f;
    end
    if (state == S_XZ) begin
      z_hold <= zone_rdata;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_top <= SW'(STACK_DEPTH))
    else $error("open-zone stack deeper than its capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push_fire |=> stack_top == $past(stack_top) + SW'(1))
    else $error("accepted enter did not push a frame");

  a_parent_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_XW) |-> (cur_parent != cur_zone))
    else $error("parent write issued for a zone that is its own parent");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!zone_we && !frm_we))
    else $error("memory written while no word is in flight");

endmodule

@@ tb/sv/nzp_stats_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nzp_stats_checker
// Watches the request and response channels of the zone profiler, keeps its
// own copy of the zone table and the open-zone stack, and compares every
// response word field by field with the statistics it predicts.
// ----------------------------------------------------------------------------
module nzp_stats_checker
  import nzp_pkg::*;
#(
  parameter int ZONES       = ZONES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  req_word_t req,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  rsp_word_t rsp,
  output int        mismatch_count,
  output int        pending_count
);

  localparam int PRINT_CAP = 100;

  bit [TICK_W-1:0]    self_mem  [ZONES];
  bit [TICK_W-1:0]    total_mem [ZONES];
  bit [TICK_W-1:0]    hit_mem   [ZONES];
  bit [TICK_W-1:0]    byte_mem  [ZONES];
  bit [TICK_W-1:0]    frm_start [STACK_DEPTH];
  bit [TICK_W-1:0]    frm_snap  [STACK_DEPTH];
  bit [ZONE_ID_W-1:0] frm_zone  [STACK_DEPTH];
  bit [ZONE_ID_W-1:0] frm_owner [STACK_DEPTH];
  int unsigned        open_depth;
  bit [ZONE_ID_W-1:0] open_zone;

  rsp_word_t   stats_due_q[$];
  rsp_word_t   oldest_due;
  rsp_word_t   fresh_due;
  int          fail_tally = 0;
  int unsigned rsp_index  = 0;

  task automatic report_mismatch(input string msg);
    if (fail_tally < PRINT_CAP)
      $display("%0t ns: response %0d: %s", $time, rsp_index, msg);
    fail_tally++;
  endtask

  task automatic check_field(input string field, input logic [TICK_W-1:0] seen,
                             input logic [TICK_W-1:0] want);
    if (seen !== want)
      report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", field, seen, want));
  endtask

  // Applies one request to the predicted state and returns the word the block
  // must answer.
  task automatic advance_profile(input req_word_t w, output rsp_word_t r);
    bit [ZONE_ID_W-1:0] zone;
    bit [ZONE_ID_W-1:0] owner;
    bit [ZONE_ID_W-1:0] shown;
    bit [TICK_W-1:0]    elapsed;
    logic [STATUS_W-1:0] st;
    zone  = ZONE_ID_W'(w.zone_id % ZONES);
    shown = zone;
    st    = ST_OK;
    case (w.cmd)
      CMD_ENTER: begin
        if (zone == 0) begin
          st    = ST_ZONE0;
          shown = '0;
        end else if (open_depth >= STACK_DEPTH) begin
          st = ST_OVERFLOW;
        end else begin
          byte_mem[zone]       += w.bytes_done;
          frm_start[open_depth] = w.now_ticks;
          frm_snap[open_depth]  = total_mem[zone];
          frm_zone[open_depth]  = zone;
          frm_owner[open_depth] = open_zone;
          open_zone             = zone;
          open_depth++;
        end
      end
      CMD_EXIT: begin
        if (open_depth == 0) begin
          st    = ST_UNDERFLOW;
          shown = '0;
        end else begin
          open_depth--;
          shown   = ZONE_ID_W'(frm_zone[open_depth] % ZONES);
          owner   = ZONE_ID_W'(frm_owner[open_depth] % ZONES);
          elapsed = w.now_ticks - frm_start[open_depth];
          hit_mem[shown]  += TICK_W'(1);
          total_mem[shown] = frm_snap[open_depth] + elapsed;
          // When a zone is its own parent these two cancel.
          self_mem[shown] += elapsed;
          self_mem[owner] -= elapsed;
          open_zone = owner;
        end
      end
      default: ;
    endcase
    r.status      = st;
    r.zone_out    = shown;
    r.self_ticks  = self_mem[shown];
    r.total_ticks = total_mem[shown];
    r.hits        = hit_mem[shown];
    r.byte_sum    = byte_mem[shown];
    r.nest_level  = open_depth[NEST_W-1:0];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ZONES; i++) begin
        self_mem[i]  = '0;
        total_mem[i] = '0;
        hit_mem[i]   = '0;
        byte_mem[i]  = '0;
      end
      open_depth = 0;
      open_zone  = '0;
      stats_due_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (stats_due_q.size() == 0) begin
          report_mismatch("word arrived with no request outstanding");
        end else begin
          oldest_due = stats_due_q.pop_front();
          check_field("status", TICK_W'(rsp.status), TICK_W'(oldest_due.status));
          check_field("zone_out", TICK_W'(rsp.zone_out), TICK_W'(oldest_due.zone_out));
          check_field("self_ticks", rsp.self_ticks, oldest_due.self_ticks);
          check_field("total_ticks", rsp.total_ticks, oldest_due.total_ticks);
          check_field("hits", rsp.hits, oldest_due.hits);
          check_field("byte_sum", rsp.byte_sum, oldest_due.byte_sum);
          check_field("nest_level", TICK_W'(rsp.nest_level),
                      TICK_W'(oldest_due.nest_level));
        end
        rsp_index++;
      end
      if (req_valid && req_ready) begin
        advance_profile(req, fresh_due);
        stats_due_q.push_back(fresh_due);
      end
    end
    pending_count  <= stats_due_q.size();
    mismatch_count <= fail_tally;
  end

endmodule

@@ tb/sv/nested_zone_time_profiler_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nested_zone_time_profiler_unit_test
// Drives enter, exit and read words into the zone profiler: a few hand-picked
// corner cases, then random nested bursts, stack-filling dives and noise,
// with random gaps on both channels. The checker beside the block judges
// every response word.
// ----------------------------------------------------------------------------
module nested_zone_time_profiler_unit_test;
  import nzp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ_ALT = 2'd3;
  localparam int ITEM_GOAL = 1200;
  localparam int POOL_HI   = 12;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [ZONE_ID_W-1:0] ZONE_LAST = ZONE_ID_W'(ZONES_DEF - 1);

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;
  int        mismatch_count;
  int        pending_count;

  int              words_sent = 0;
  bit              calm       = 1'b0;
  logic [TICK_W-1:0] tick_now = '0;

  always #4 clk = ~clk;

  nested_zone_time_profiler_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  nzp_stats_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A small pool of zones makes recursion and repeated hits common.
  function automatic logic [ZONE_ID_W-1:0] pick_zone(input bit nonzero);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return ZONE_ID_W'($urandom_range(1, POOL_HI));
    if (roll < 95 || nonzero) return ZONE_ID_W'($urandom_range(1, ZONES_DEF - 1));
    return '0;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] op, input logic [ZONE_ID_W-1:0] zone,
                           input logic [BYTES_W-1:0] bytes, input logic [TICK_W-1:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{cmd: op, zone_id: zone, bytes_done: bytes, now_ticks: stamp};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic enter_zone(input logic [ZONE_ID_W-1:0] zone);
    tick_now += $urandom_range(1, 500);
    send_word(CMD_ENTER, zone, $urandom, tick_now);
  endtask

  // Exit ignores the zone and byte fields, so they carry random bits.
  task automatic leave_zone();
    tick_now += $urandom_range(1, 500);
    send_word(CMD_EXIT, ZONE_ID_W'($urandom_range(0, ZONES_DEF - 1)), $urandom, tick_now);
  endtask

  task automatic read_zone(input logic [ZONE_ID_W-1:0] zone);
    tick_now += $urandom_range(0, 50);
    send_word(($urandom_range(0, 3) == 0) ? CMD_READ_ALT : CMD_READ, zone, $urandom,
              tick_now);
  endtask

  task automatic nested_burst();
    int depth;
    depth = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) tick_now = {$urandom, $urandom};
    repeat (depth) begin
      enter_zone(pick_zone(1'b0));
      if ($urandom_range(0, 3) == 0) read_zone(pick_zone(1'b0));
    end
    repeat (depth) begin
      leave_zone();
      if ($urandom_range(0, 3) == 0) read_zone(pick_zone(1'b0));
    end
  endtask

  // Fills the stack past its limit, then unwinds past empty.
  task automatic deep_dive();
    int pushes;
    pushes = STACK_DEPTH_DEF + $urandom_range(1, 4);
    repeat (pushes) enter_zone(pick_zone(1'b1));
    repeat (pushes + $urandom_range(0, 3)) leave_zone();
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8))
      send_word(CMD_W'($urandom_range(0, 3)), ZONE_ID_W'($urandom_range(0, ZONES_DEF - 1)),
                $urandom, {$urandom, $urandom});
  endtask

  initial begin : rsp_pacing
    int roll;
    @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (roll < 55) begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else if (roll < 92) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int roll;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_READ, '0, '0, '0);
    send_word(CMD_EXIT, '1, '1, TICK_MAX);
    send_word(CMD_ENTER, '0, '1, 64'd3);
    send_word(CMD_ENTER, ZONE_LAST, '1, '0);
    // Same zone again: it becomes its own parent.
    send_word(CMD_ENTER, ZONE_LAST, '0, 64'd10);
    send_word(CMD_EXIT, '0, '0, TICK_MAX);
    send_word(CMD_EXIT, '0, '0, 64'd5);
    send_word(CMD_READ_ALT, ZONE_LAST, '0, '0);
    send_word(CMD_ENTER, 12'd1, 32'd1, 64'hFFFF_FFFF_FFFF_FFF0);
    send_word(CMD_ENTER, 12'd2, 32'h8000_0000, 64'h10);
    send_word(CMD_EXIT, '0, '0, 64'h30);
    // The outer exit's timestamp has wrapped past its start.
    send_word(CMD_EXIT, '0, '0, 64'h40);
    send_word(CMD_READ, 12'd1, '0, '0);
    send_word(CMD_READ, 12'd2, '0, '0);
    send_word(CMD_EXIT, '0, '0, '0);

    while (words_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 6) deep_dive();
      else if (roll < 80) nested_burst();
      else noise_burst();
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
